@@ rtl/core/csim_pkg.sv @@
`timescale 1ns / 1ps

package csim_pkg;

	localparam int FRAC_BITS = 14;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int SIM_W     = 16;
	localparam int ONE_Q14   = 1 << FRAC_BITS;

	typedef enum logic [7:0] {
		F_IDLE = 8'b0000_0001,
		F_LOAD = 8'b0000_0010,
		F_MULP = 8'b0000_0100,
		F_MULM = 8'b0000_1000,
		F_ADD1 = 8'b0001_0000,
		F_ADD2 = 8'b0010_0000,
		F_CMP  = 8'b0100_0000,
		F_UPD  = 8'b1000_0000
	} fin_state_t;

	typedef struct packed {
		logic                    idle;
		logic                    done;
		logic signed [SIM_W-1:0] similarity;
		logic                    zero_norm;
	} fin_stat_t;

endpackage

@@ rtl/core/csim_accum.sv @@
`timescale 1ns / 1ps

module csim_accum #(
	parameter int ELEM_WIDTH = 16,
	parameter int DOT_W      = 42
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         clear,
	input  logic signed [ELEM_WIDTH-1:0] a,
	input  logic signed [ELEM_WIDTH-1:0] b,
	output logic signed [DOT_W-1:0]      dot,
	output logic        [DOT_W-2:0]      sa,
	output logic        [DOT_W-2:0]      sb
);

	localparam int SUMSQ_W = DOT_W - 1;
	localparam int PROD_W  = 2 * ELEM_WIDTH;

	logic signed [PROD_W-1:0] ab;
	logic signed [PROD_W-1:0] aa;
	logic signed [PROD_W-1:0] bb;
	logic        [DOT_W:0]    dot_sum;
	logic        [SUMSQ_W:0]  sa_sum;
	logic        [SUMSQ_W:0]  sb_sum;
	logic        [DOT_W-1:0]  dot_next;
	logic        [SUMSQ_W-1:0] sa_next;
	logic        [SUMSQ_W-1:0] sb_next;
	logic        [DOT_W-1:0]  dot_q;
	logic        [SUMSQ_W-1:0] sa_q;
	logic        [SUMSQ_W-1:0] sb_q;

	assign ab = a * b;
	assign aa = a * a;
	assign bb = b * b;

	assign dot_sum = {dot_q[DOT_W-1], dot_q} + {{(DOT_W+1-PROD_W){ab[PROD_W-1]}}, ab};
	assign sa_sum  = {1'b0, sa_q} + {{(SUMSQ_W+2-PROD_W){1'b0}}, aa[PROD_W-2:0]};
	assign sb_sum  = {1'b0, sb_q} + {{(SUMSQ_W+2-PROD_W){1'b0}}, bb[PROD_W-2:0]};

	always_comb begin
		if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
			dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
		end else begin
			dot_next = dot_sum[DOT_W-1:0];
		end
		sa_next = sa_sum[SUMSQ_W] ? {SUMSQ_W{1'b1}} : sa_sum[SUMSQ_W-1:0];
		sb_next = sb_sum[SUMSQ_W] ? {SUMSQ_W{1'b1}} : sb_sum[SUMSQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end else if (clear) begin
			dot_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end else if (en) begin
			dot_q <= dot_next;
			sa_q  <= sa_next;
			sb_q  <= sb_next;
		end
	end

	assign dot = $signed(dot_q);
	assign sa  = sa_q;
	assign sb  = sb_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (dot_q == '0) && (sa_q == '0) && (sb_q == '0))
		else $error("accumulators not emptied");

endmodule

@@ rtl/core/csim_addsub.sv @@
`timescale 1ns / 1ps

module csim_addsub #(
	parameter int W = 113
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	assign {carry, sum} = {1'b0, x} + {1'b0, y ^ {W{sub}}} + {{W{1'b0}}, sub};

endmodule

@@ rtl/core/csim_finish.sv @@
`timescale 1ns / 1ps

module csim_finish #(
	parameter int DOT_W = 42
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    out_free,
	input  logic signed [DOT_W-1:0] dot,
	input  logic        [DOT_W-2:0] sa,
	input  logic        [DOT_W-2:0] sb,
	output logic                    clear,
	output csim_pkg::fin_stat_t     stat
);

	import csim_pkg::*;

	localparam int WIDE_W = 2 * DOT_W + 2 * FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(DOT_W);

	fin_state_t            state_q;
	logic [WIDE_W-1:0]     acc_q;
	logic [WIDE_W-1:0]     p_q;
	logic [WIDE_W-1:0]     r_q;
	logic [WIDE_W-1:0]     s_q;
	logic [WIDE_W-1:0]     u_q;
	logic [WIDE_W-1:0]     v_q;
	logic [DOT_W-1:0]      mcand_q;
	logic [DOT_W-1:0]      mplier_q;
	logic [DOT_W-1:0]      mag_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [Q_W-1:0]        q_q;
	logic [Q_W-1:0]        bit_q;
	logic                  neg_q;
	logic                  zero_q;
	logic                  done_q;

	logic [WIDE_W-1:0]     add_x;
	logic [WIDE_W-1:0]     add_y;
	logic                  add_sub;
	logic [WIDE_W-1:0]     add_sum;
	logic                  add_carry;
	logic [DOT_W-1:0]      dot_mag;
	logic                  take;
	logic [SIM_W-1:0]      q_ext;

	csim_addsub #(.W(WIDE_W)) u_addsub (
		.x     (add_x),
		.y     (add_y),
		.sub   (add_sub),
		.sum   (add_sum),
		.carry (add_carry)
	);

	assign dot_mag = dot[DOT_W-1] ? (~dot + 1'b1) : dot;
	assign take    = add_carry && !q_q[Q_W-1];

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			F_MULP, F_MULM: begin
				add_x = acc_q << 1;
				add_y = mplier_q[DOT_W-1] ? {{(WIDE_W-DOT_W){1'b0}}, mcand_q} : '0;
			end
			F_ADD1: begin
				add_x = s_q;
				add_y = u_q;
			end
			F_ADD2: begin
				add_x = acc_q;
				add_y = v_q;
			end
			F_CMP: begin
				add_x   = r_q;
				add_y   = acc_q;
				add_sub = 1'b1;
			end
			F_UPD: begin
				add_x = u_q >> 1;
				add_y = v_q;
			end
			default: begin
				add_x = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (done_q && out_free) begin
						done_q <= 1'b0;
					end else if (start) begin
						state_q <= F_LOAD;
					end
				end
				F_LOAD: begin
					state_q <= ((sa == '0) || (sb == '0)) ? F_IDLE : F_MULP;
					done_q  <= (sa == '0) || (sb == '0);
				end
				F_MULP: begin
					if (cnt_q == '0) begin
						state_q <= F_MULM;
					end
				end
				F_MULM: begin
					if (cnt_q == '0) begin
						state_q <= F_ADD1;
					end
				end
				F_ADD1: begin
					state_q <= F_ADD2;
				end
				F_ADD2: begin
					state_q <= F_CMP;
				end
				F_CMP: begin
					if (bit_q[0]) begin
						state_q <= F_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= take ? F_UPD : F_ADD1;
					end
				end
				F_UPD: begin
					state_q <= F_ADD1;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_LOAD: begin
				neg_q    <= dot[DOT_W-1];
				zero_q   <= (sa == '0) || (sb == '0);
				mag_q    <= dot_mag;
				mcand_q  <= {1'b0, sa};
				mplier_q <= {1'b0, sb};
				acc_q    <= '0;
				cnt_q    <= CNT_W'(DOT_W - 1);
				q_q      <= '0;
			end
			F_MULP: begin
				acc_q    <= add_sum;
				mplier_q <= mplier_q << 1;
				cnt_q    <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					p_q      <= add_sum;
					acc_q    <= '0;
					mcand_q  <= mag_q;
					mplier_q <= mag_q;
					cnt_q    <= CNT_W'(DOT_W - 1);
				end
			end
			F_MULM: begin
				acc_q    <= add_sum;
				mplier_q <= mplier_q << 1;
				cnt_q    <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					r_q   <= add_sum << (2 * FRAC_BITS);
					s_q   <= '0;
					u_q   <= '0;
					v_q   <= p_q << (2 * FRAC_BITS);
					bit_q <= {1'b1, {(Q_W-1){1'b0}}};
				end
			end
			F_ADD1, F_ADD2: begin
				acc_q <= add_sum;
			end
			F_CMP: begin
				if (take) begin
					s_q <= acc_q;
					q_q <= q_q | bit_q;
				end else begin
					u_q   <= u_q >> 1;
					v_q   <= v_q >> 2;
					bit_q <= bit_q >> 1;
				end
			end
			F_UPD: begin
				u_q   <= add_sum;
				v_q   <= v_q >> 2;
				bit_q <= bit_q >> 1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign q_ext = {{(SIM_W-Q_W){1'b0}}, q_q};

	assign clear           = (state_q == F_LOAD);
	assign stat.idle       = (state_q == F_IDLE) && !done_q;
	assign stat.done       = (state_q == F_IDLE) && done_q && out_free;
	assign stat.similarity = $signed(neg_q ? (~q_ext + 1'b1) : q_ext);
	assign stat.zero_norm  = zero_q;

	a_done_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> out_free)
		else $error("result issued without a free output slot");

	a_clamp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_CMP) |-> !(q_q[Q_W-1] && (q_q[Q_W-2:0] != '0)))
		else $error("quotient beyond unity");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != F_IDLE) |-> !start)
		else $error("request taken while busy");

endmodule

@@ rtl/core/cosine_similarity_stream.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Payload
// s_*      in         s_tvalid / s_tready      tdata: elem_a, elem_b; tlast: last_pair
// m_*      out        m_tvalid / m_tready      tdata: similarity; tuser: zero_norm
//
// A pair without tlast is accumulated when taken; pairs may stream back to back while s_tready is high.
// A pair with tlast holds s_tready low while one shared wide adder forms
// sum_a*sum_b and dot^2 by shift-add (DOT_W = 2*ELEM_WIDTH + log2(MAX_DIM))
// and then a root search that settles the result one bit at a time; when a
// sum of squares is zero, the search is skipped and the result is zero.
// Reset clears the accumulators and the control state at once.
// A stalled output holds its result; the next vector streams in meanwhile.

module cosine_similarity_stream #(
	parameter int ELEM_WIDTH = 16,
	parameter int MAX_DIM    = 1024,
	localparam int S_DATA_W  = ((2 * ELEM_WIDTH + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [S_DATA_W-1:0]        s_tdata,   // elem_a, elem_b
	input  logic                       s_tlast,   // last_pair
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [csim_pkg::SIM_W-1:0] m_tdata,   // similarity
	output logic                       m_tuser    // zero_norm
);

	import csim_pkg::*;

	localparam int DOT_W = 2 * ELEM_WIDTH + $clog2(MAX_DIM);

	logic signed [ELEM_WIDTH-1:0] elem_a;
	logic signed [ELEM_WIDTH-1:0] elem_b;
	logic                         accept;
	logic                         start;
	logic                         clear;
	logic                         out_free;
	logic signed [DOT_W-1:0]      dot;
	logic        [DOT_W-2:0]      sa;
	logic        [DOT_W-2:0]      sb;
	fin_stat_t                    stat;
	logic                         m_tvalid_q;
	logic [SIM_W-1:0]             m_tdata_q;
	logic                         m_tuser_q;

	assign elem_a   = $signed(s_tdata[ELEM_WIDTH-1:0]);
	assign elem_b   = $signed(s_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]);
	assign s_tready = stat.idle;
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && s_tlast;
	assign out_free = !m_tvalid_q || m_tready;

	csim_accum #(.ELEM_WIDTH(ELEM_WIDTH), .DOT_W(DOT_W)) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.clear  (clear),
		.a      (elem_a),
		.b      (elem_b),
		.dot    (dot),
		.sa     (sa),
		.sb     (sb)
	);

	csim_finish #(.DOT_W(DOT_W)) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.dot      (dot),
		.sa       (sa),
		.sb       (sb),
		.clear    (clear),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			m_tdata_q <= stat.similarity;
			m_tuser_q <= stat.zero_norm;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("input not held after the final pair");

	a_zero_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("zero magnitude with nonzero similarity");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(m_tdata) <= ONE_Q14) && ($signed(m_tdata) >= -ONE_Q14)))
		else $error("similarity out of range");

endmodule
